/* hdl/cpc_pkg.sv */
package cpc_pkg;

  // Extra fraction bits carried by the coordinates inside the datapath.
  localparam int GUARD_BITS = 8;
  // Width of an external angle (fraction of a full turn).
  localparam int ANGLE_W = 16;
  // Width of an internal angle (fraction of a full turn, wraps modulo one turn).
  localparam int TURN_W = 32;
  // Number of arctangent entries available, which bounds the iteration count.
  localparam int ATAN_ENTRIES = 24;
  // Width of the point class code.
  localparam int CLASS_W = 3;

  // Inverse of the CORDIC gain as a 32-bit fraction (0.607252935).
  localparam logic [TURN_W-1:0] INV_GAIN = 32'd2608131496;
  localparam logic [TURN_W-1:0] HALF_TURN = 32'h8000_0000;
  // Half of one external angle step, used to round internal angles.
  localparam logic [TURN_W-1:0] ANGLE_ROUND = 32'h0000_8000;

  typedef enum logic {
    MODE_TO_POLAR = 1'b0,
    MODE_TO_CART  = 1'b1
  } cpc_mode_t;

  typedef enum logic [CLASS_W-1:0] {
    CLS_Q1     = 3'd0,
    CLS_Q2     = 3'd1,
    CLS_Q3     = 3'd2,
    CLS_Q4     = 3'd3,
    CLS_X_AXIS = 3'd4,
    CLS_Y_AXIS = 3'd5
  } cpc_class_t;

  // Control that travels with every pipeline stage.
  typedef struct packed {
    logic      vld;
    cpc_mode_t mode;
  } cpc_ctl_t;

  // atan(2^-idx) as a 32-bit fraction of a full turn.
  function automatic logic [TURN_W-1:0] atan_turn(input logic [4:0] idx);
    logic [TURN_W-1:0] val;
    case (idx)
      5'd0:    val = 32'h2000_0000;
      5'd1:    val = 32'h12E4_051E;
      5'd2:    val = 32'h09FB_385B;
      5'd3:    val = 32'h0511_11D4;
      5'd4:    val = 32'h028B_0D43;
      5'd5:    val = 32'h0145_D7E1;
      5'd6:    val = 32'h00A2_F61E;
      5'd7:    val = 32'h0051_7C55;
      5'd8:    val = 32'h0028_BE53;
      5'd9:    val = 32'h0014_5F2F;
      5'd10:   val = 32'h000A_2F98;
      5'd11:   val = 32'h0005_17CC;
      5'd12:   val = 32'h0002_8BE6;
      5'd13:   val = 32'h0001_45F3;
      5'd14:   val = 32'h0000_A2FA;
      5'd15:   val = 32'h0000_517D;
      5'd16:   val = 32'h0000_28BE;
      5'd17:   val = 32'h0000_145F;
      5'd18:   val = 32'h0000_0A30;
      5'd19:   val = 32'h0000_0518;
      5'd20:   val = 32'h0000_028C;
      5'd21:   val = 32'h0000_0146;
      5'd22:   val = 32'h0000_00A3;
      5'd23:   val = 32'h0000_0051;
      default: val = '0;
    endcase
    return val;
  endfunction

  // Quadrant or axis of a point, given the sign and zero flags of x and y.
  function automatic cpc_class_t classify(input logic x_neg, input logic x_zero,
                                          input logic y_neg, input logic y_zero);
    cpc_class_t cls;
    if (!x_zero && !y_zero) begin
      case ({x_neg, y_neg})
        2'b00:   cls = CLS_Q1;
        2'b10:   cls = CLS_Q2;
        2'b11:   cls = CLS_Q3;
        default: cls = CLS_Q4;
      endcase
    end else if (!x_zero) begin
      cls = CLS_X_AXIS;
    end else begin
      cls = CLS_Y_AXIS;
    end
    return cls;
  endfunction

endpackage

/* hdl/cpc_gain.sv */
module cpc_gain #(
  parameter int IW     = 23,
  parameter int SIDE_W = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cpc_pkg::cpc_ctl_t   up_ctl,
  input  logic [IW-1:0]       up_mag,
  input  logic [SIDE_W-1:0]   up_side,
  output logic                up_ready,
  input  logic                dn_ready,
  output cpc_pkg::cpc_ctl_t   dn_ctl,
  output logic [IW-1:0]       dn_mag,
  output logic [SIDE_W-1:0]   dn_side
);
  import cpc_pkg::*;

  localparam int HW = TURN_W / 2;
  localparam int PW = IW + HW;
  localparam int SW = IW + TURN_W + 1;
  localparam logic [HW-1:0] INV_HI = INV_GAIN[TURN_W-1:HW];
  localparam logic [HW-1:0] INV_LO = INV_GAIN[HW-1:0];
  localparam logic [SW-1:0] RND = SW'(HALF_TURN);

  // The 32-bit constant is split in halves so that each multiply stays narrow.
  cpc_ctl_t          ctl_a_r;
  logic [PW-1:0]     hi_a_r;
  logic [PW-1:0]     lo_a_r;
  logic [SIDE_W-1:0] side_a_r;
  cpc_ctl_t          ctl_b_r;
  logic [IW-1:0]     mag_b_r;
  logic [SIDE_W-1:0] side_b_r;

  logic [PW-1:0] hi_nxt;
  logic [PW-1:0] lo_nxt;
  logic [SW-1:0] sum;
  logic [IW-1:0] mag_nxt;
  logic          en_a;
  logic          en_b;

  assign en_b     = !ctl_b_r.vld || dn_ready;
  assign en_a     = !ctl_a_r.vld || en_b;
  assign up_ready = en_a;

  assign hi_nxt  = PW'(up_mag) * PW'(INV_HI);
  assign lo_nxt  = PW'(up_mag) * PW'(INV_LO);
  assign sum     = {1'b0, hi_a_r, {HW{1'b0}}} + SW'(lo_a_r) + RND;
  assign mag_nxt = sum[IW+TURN_W-1:TURN_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
    end else begin
      if (en_a) begin
        ctl_a_r <= up_ctl;
      end
      if (en_b) begin
        ctl_b_r <= ctl_a_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      hi_a_r   <= hi_nxt;
      lo_a_r   <= lo_nxt;
      side_a_r <= up_side;
    end
    if (en_b) begin
      mag_b_r  <= mag_nxt;
      side_b_r <= side_a_r;
    end
  end

  assign dn_ctl  = ctl_b_r;
  assign dn_mag  = mag_b_r;
  assign dn_side = side_b_r;

endmodule

/* hdl/cpc_stage.sv */
module cpc_stage #(
  parameter int SHIFT  = 0,
  parameter int DW     = 27,
  parameter int SIDE_W = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cpc_pkg::cpc_ctl_t      up_ctl,
  input  logic signed [DW-1:0]   up_x,
  input  logic signed [DW-1:0]   up_y,
  input  logic [31:0]            up_z,
  input  logic [SIDE_W-1:0]      up_side,
  output logic                   up_ready,
  input  logic                   dn_ready,
  output cpc_pkg::cpc_ctl_t      dn_ctl,
  output logic signed [DW-1:0]   dn_x,
  output logic signed [DW-1:0]   dn_y,
  output logic [31:0]            dn_z,
  output logic [SIDE_W-1:0]      dn_side
);
  import cpc_pkg::*;

  localparam logic [TURN_W-1:0] ATAN = atan_turn(5'(SHIFT));

  cpc_ctl_t              ctl_r;
  logic signed [DW-1:0]  x_r;
  logic signed [DW-1:0]  y_r;
  logic [TURN_W-1:0]     z_r;
  logic [SIDE_W-1:0]     side_r;

  logic signed [DW-1:0]  dx;
  logic signed [DW-1:0]  dy;
  logic signed [DW-1:0]  x_nxt;
  logic signed [DW-1:0]  y_nxt;
  logic [TURN_W-1:0]     z_nxt;
  logic                  ccw;
  logic                  en;

  assign en       = !ctl_r.vld || dn_ready;
  assign up_ready = en;

  // Vectoring drives y toward zero, rotation drives the residual angle toward zero.
  assign ccw = (up_ctl.mode == MODE_TO_CART) ? !up_z[TURN_W-1] : up_y[DW-1];
  assign dx  = up_y >>> SHIFT;
  assign dy  = up_x >>> SHIFT;

  always_comb begin
    if (ccw) begin
      x_nxt = up_x - dx;
      y_nxt = up_y + dy;
      z_nxt = up_z - ATAN;
    end else begin
      x_nxt = up_x + dx;
      y_nxt = up_y - dy;
      z_nxt = up_z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= up_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      side_r <= up_side;
    end
  end

  assign dn_ctl  = ctl_r;
  assign dn_x    = x_r;
  assign dn_y    = y_r;
  assign dn_z    = z_r;
  assign dn_side = side_r;

endmodule

/* hdl/cartesian_polar_converter.sv */
// Cartesian/polar converter built as a fully unrolled CORDIC pipeline. Each input beat
// carries a mode in in_tuser: mode 0 turns a signed Q7.8 point (x, y) into a Q8.8
// radius and an angle, mode 1 turns a radius and an angle into a signed Q7.8 point.
// Angles are 16-bit fractions of a full turn. Every result beat also carries a point
// class in out_tuser (quadrants one to four, on the x axis, or on the y axis, which
// includes the origin); fields that a mode does not compute are echoed from the input.
// The block accepts one beat per clock unless out_tready holds the output back, and it
// returns one result beat per input beat, in order. A beat passes the registered gain
// multiply ahead of the rotation, the register of each micro-rotation stage, the gain
// multiply after vectoring and the output register, which rounds and saturates. The
// chain of micro-rotation stages sets both the latency and the depth.
module cartesian_polar_converter #(
  parameter int CORDIC_STEPS = 16,
  parameter int COORD_WIDTH  = 16
) (
  input  logic clk,
  input  logic rst_n,

  input  logic in_tvalid,
  output logic in_tready,
  // From bit 0 up: x_in, y_in, radius_in, angle_in, zero padding.
  input  logic [((3*COORD_WIDTH+15)+7)/8*8-1:0] in_tdata,
  // mode: 0 cartesian to polar, 1 polar to cartesian.
  input  logic in_tuser,

  output logic out_tvalid,
  input  logic out_tready,
  // From bit 0 up: radius_out, angle_out, x_out, y_out, zero padding.
  output logic [((3*COORD_WIDTH+16)+7)/8*8-1:0] out_tdata,
  // point_class.
  output logic [2:0] out_tuser
);
  import cpc_pkg::*;

  localparam int CW      = COORD_WIDTH;
  localparam int OUT_DW  = ((3*CW+16)+7)/8*8;
  // Datapath width: vectoring grows a point by up to sqrt(2) times the CORDIC gain.
  localparam int DW      = CW + GUARD_BITS + 3;
  localparam int PRE_W   = CW - 1 + GUARD_BITS;
  localparam int POST_W  = CW + GUARD_BITS + 1;
  localparam int ROUND_HALF = 1 << (GUARD_BITS - 1);

  // Fields that ride along unchanged from the input register to the output register.
  typedef struct packed {
    logic [CW-1:0]      x_raw;
    logic [CW-1:0]      y_raw;
    logic [CW-2:0]      rr;
    logic [ANGLE_W-1:0] ar;
    cpc_class_t         cls;
    logic               zero;
    logic               flip;
  } echo_t;

  localparam int ECHO_W = $bits(echo_t);
  localparam int SIDE_W = ECHO_W + 2*DW + TURN_W;

  // Saturate a rounded coordinate to the signed output range.
  function automatic logic [CW-1:0] sat_coord(input logic [CW+3:0] v);
    logic ovf;
    logic [CW-1:0] res;
    ovf = !(&v[CW+3:CW-1] || !(|v[CW+3:CW-1]));
    if (ovf) begin
      res = v[CW+3] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else begin
      res = v[CW-1:0];
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------------
  // Input decode. Vectoring starts from the right half-plane: a point with negative x
  // is mirrored through the origin and the angle starts at half a turn. Rotation starts
  // within a quarter turn of zero: an angle in the second or third quarter is moved by
  // half a turn and the resulting point is mirrored back after the last stage.
  // ---------------------------------------------------------------------------------
  logic signed [CW-1:0]  x_in;
  logic signed [CW-1:0]  y_in;
  logic [CW-2:0]         rr_in;
  logic [ANGLE_W-1:0]    ar_in;
  cpc_mode_t             mode_in;
  logic signed [DW-1:0]  x_sc;
  logic signed [DW-1:0]  y_sc;
  logic signed [DW-1:0]  x0;
  logic signed [DW-1:0]  y0;
  logic [TURN_W-1:0]     z_turn;
  logic [TURN_W-1:0]     z_init;
  logic                  quad_flip;
  echo_t                 echo_in;
  cpc_ctl_t              pre_ctl_in;
  logic [PRE_W-1:0]      pre_mag_in;
  logic [SIDE_W-1:0]     pre_side_in;

  assign x_in    = in_tdata[CW-1:0];
  assign y_in    = in_tdata[2*CW-1:CW];
  assign rr_in   = in_tdata[3*CW-2:2*CW];
  assign ar_in   = in_tdata[3*CW+ANGLE_W-2:3*CW-1];
  assign mode_in = cpc_mode_t'(in_tuser);

  assign x_sc = {{(DW-CW-GUARD_BITS){x_in[CW-1]}}, x_in, {GUARD_BITS{1'b0}}};
  assign y_sc = {{(DW-CW-GUARD_BITS){y_in[CW-1]}}, y_in, {GUARD_BITS{1'b0}}};
  assign x0   = x_in[CW-1] ? -x_sc : x_sc;
  assign y0   = x_in[CW-1] ? -y_sc : y_sc;

  assign z_turn    = {ar_in, {(TURN_W-ANGLE_W){1'b0}}};
  assign quad_flip = z_turn[TURN_W-1] ^ z_turn[TURN_W-2];

  always_comb begin
    if (mode_in == MODE_TO_CART) begin
      z_init = quad_flip ? (z_turn - HALF_TURN) : z_turn;
    end else begin
      z_init = x_in[CW-1] ? HALF_TURN : '0;
    end
  end

  always_comb begin
    echo_in.x_raw = x_in;
    echo_in.y_raw = y_in;
    echo_in.rr    = rr_in;
    echo_in.ar    = ar_in;
    echo_in.cls   = classify(x_in[CW-1], x_in == '0, y_in[CW-1], y_in == '0);
    echo_in.zero  = (x_in == '0) && (y_in == '0);
    echo_in.flip  = (mode_in == MODE_TO_CART) && quad_flip;
    pre_ctl_in.vld  = in_tvalid;
    pre_ctl_in.mode = mode_in;
  end

  // In rotation mode the input radius is scaled by the inverse gain before rotating.
  assign pre_mag_in  = {rr_in, {GUARD_BITS{1'b0}}};
  assign pre_side_in = {echo_in, x0, y0, z_init};

  cpc_ctl_t          pre_ctl_out;
  logic [PRE_W-1:0]  pre_mag_out;
  logic [SIDE_W-1:0] pre_side_out;
  logic signed [DW-1:0] pre_x0;
  logic signed [DW-1:0] pre_y0;

  // Ready chain: each stage takes a new beat when it is empty or its successor moves.
  cpc_ctl_t             cctl  [CORDIC_STEPS+1];
  logic signed [DW-1:0] cx    [CORDIC_STEPS+1];
  logic signed [DW-1:0] cy    [CORDIC_STEPS+1];
  logic [TURN_W-1:0]    cz    [CORDIC_STEPS+1];
  logic [ECHO_W-1:0]    cside [CORDIC_STEPS+1];
  logic [CORDIC_STEPS:0] crdy;

  cpc_gain #(
    .IW     (PRE_W),
    .SIDE_W (SIDE_W)
  ) u_pre_gain (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_ctl   (pre_ctl_in),
    .up_mag   (pre_mag_in),
    .up_side  (pre_side_in),
    .up_ready (in_tready),
    .dn_ready (crdy[0]),
    .dn_ctl   (pre_ctl_out),
    .dn_mag   (pre_mag_out),
    .dn_side  (pre_side_out)
  );

  assign pre_x0 = pre_side_out[2*DW+TURN_W-1 -: DW];
  assign pre_y0 = pre_side_out[DW+TURN_W-1 -: DW];

  // Start of the rotation chain: rotation mode starts from (scaled radius, 0).
  assign cctl[0]  = pre_ctl_out;
  assign cx[0]    = (pre_ctl_out.mode == MODE_TO_CART) ?
                    DW'({{(DW-PRE_W){1'b0}}, pre_mag_out}) : pre_x0;
  assign cy[0]    = (pre_ctl_out.mode == MODE_TO_CART) ? '0 : pre_y0;
  assign cz[0]    = pre_side_out[TURN_W-1:0];
  assign cside[0] = pre_side_out[SIDE_W-1 -: ECHO_W];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    cpc_stage #(
      .SHIFT  (i),
      .DW     (DW),
      .SIDE_W (ECHO_W)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_ctl   (cctl[i]),
      .up_x     (cx[i]),
      .up_y     (cy[i]),
      .up_z     (cz[i]),
      .up_side  (cside[i]),
      .up_ready (crdy[i]),
      .dn_ready (crdy[i+1]),
      .dn_ctl   (cctl[i+1]),
      .dn_x     (cx[i+1]),
      .dn_y     (cy[i+1]),
      .dn_z     (cz[i+1]),
      .dn_side  (cside[i+1])
    );
  end

  // ---------------------------------------------------------------------------------
  // After the last micro-rotation: vectoring leaves a positive x that is the scaled
  // radius and goes through the second gain multiply; rotation mirrors its point back
  // if the angle was moved by half a turn.
  // ---------------------------------------------------------------------------------
  echo_t                last_echo;
  logic signed [DW-1:0] xf;
  logic signed [DW-1:0] yf;
  logic [POST_W-1:0]    post_mag_in;
  logic [SIDE_W-1:0]    post_side_in;
  cpc_ctl_t             post_ctl_out;
  logic [POST_W-1:0]    post_mag_out;
  logic [SIDE_W-1:0]    post_side_out;
  logic                 en_out;

  assign last_echo    = echo_t'(cside[CORDIC_STEPS]);
  assign xf           = last_echo.flip ? -cx[CORDIC_STEPS] : cx[CORDIC_STEPS];
  assign yf           = last_echo.flip ? -cy[CORDIC_STEPS] : cy[CORDIC_STEPS];
  assign post_mag_in  = cx[CORDIC_STEPS][POST_W-1:0];
  assign post_side_in = {cside[CORDIC_STEPS], xf, yf, cz[CORDIC_STEPS]};

  cpc_gain #(
    .IW     (POST_W),
    .SIDE_W (SIDE_W)
  ) u_post_gain (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_ctl   (cctl[CORDIC_STEPS]),
    .up_mag   (post_mag_in),
    .up_side  (post_side_in),
    .up_ready (crdy[CORDIC_STEPS]),
    .dn_ready (en_out),
    .dn_ctl   (post_ctl_out),
    .dn_mag   (post_mag_out),
    .dn_side  (post_side_out)
  );

  // ---------------------------------------------------------------------------------
  // Output stage: drop the guard bits with round-half-up, saturate, round the angle
  // to 16 bits and classify. The origin in vectoring mode reports radius and angle 0.
  // ---------------------------------------------------------------------------------
  echo_t                 fin_echo;
  logic signed [DW-1:0]  fin_x;
  logic signed [DW-1:0]  fin_y;
  logic [TURN_W-1:0]     fin_z;
  logic [POST_W:0]       rad_sum;
  logic [CW+1:0]         rad_rnd;
  logic [CW-1:0]         rad_sat;
  logic [TURN_W-1:0]     ang_sum;
  logic signed [DW:0]    xs;
  logic signed [DW:0]    ys;
  logic [CW-1:0]         xo;
  logic [CW-1:0]         yo;

  logic [CW-1:0]      rad_nxt;
  logic [ANGLE_W-1:0] ang_nxt;
  logic [CW-1:0]      x_nxt;
  logic [CW-1:0]      y_nxt;
  cpc_class_t         cls_nxt;

  logic               out_valid_r;
  cpc_mode_t          out_mode_r;
  logic [CW-1:0]      out_rad_r;
  logic [ANGLE_W-1:0] out_ang_r;
  logic [CW-1:0]      out_x_r;
  logic [CW-1:0]      out_y_r;
  cpc_class_t         out_cls_r;

  assign fin_echo = echo_t'(post_side_out[SIDE_W-1 -: ECHO_W]);
  assign fin_x    = post_side_out[2*DW+TURN_W-1 -: DW];
  assign fin_y    = post_side_out[DW+TURN_W-1 -: DW];
  assign fin_z    = post_side_out[TURN_W-1:0];

  assign rad_sum = {1'b0, post_mag_out} + (POST_W+1)'(ROUND_HALF);
  assign rad_rnd = rad_sum[POST_W:GUARD_BITS];
  assign rad_sat = (|rad_rnd[CW+1:CW]) ? {CW{1'b1}} : rad_rnd[CW-1:0];
  assign ang_sum = fin_z + ANGLE_ROUND;

  assign xs = {fin_x[DW-1], fin_x} + (DW+1)'(ROUND_HALF);
  assign ys = {fin_y[DW-1], fin_y} + (DW+1)'(ROUND_HALF);
  assign xo = sat_coord(xs[DW:GUARD_BITS]);
  assign yo = sat_coord(ys[DW:GUARD_BITS]);

  always_comb begin
    if (post_ctl_out.mode == MODE_TO_CART) begin
      rad_nxt = {1'b0, fin_echo.rr};
      ang_nxt = fin_echo.ar;
      x_nxt   = xo;
      y_nxt   = yo;
      cls_nxt = classify(xo[CW-1], xo == '0, yo[CW-1], yo == '0);
    end else begin
      rad_nxt = fin_echo.zero ? '0 : rad_sat;
      ang_nxt = fin_echo.zero ? '0 : ang_sum[TURN_W-1:TURN_W-ANGLE_W];
      x_nxt   = fin_echo.x_raw;
      y_nxt   = fin_echo.y_raw;
      cls_nxt = fin_echo.cls;
    end
  end

  // The output register holds a finished beat while the earlier stages keep filling.
  assign en_out = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= post_ctl_out.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_mode_r <= post_ctl_out.mode;
      out_rad_r  <= rad_nxt;
      out_ang_r  <= ang_nxt;
      out_x_r    <= x_nxt;
      out_y_r    <= y_nxt;
      out_cls_r  <= cls_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DW'({out_y_r, out_x_r, out_ang_r, out_rad_r});
  assign out_tuser  = out_cls_r;

`ifndef SYNTHESIS
  // With the output register empty, every stage can move, so the input must be open.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input not ready while the pipeline can advance");

  // A point reported on the y axis has x equal to zero.
  a_class_y_axis: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_cls_r == CLS_Y_AXIS) |-> (out_x_r == '0))
    else $error("y-axis class with nonzero x");

  // A point reported on the x axis has y equal to zero and x nonzero.
  a_class_x_axis: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_cls_r == CLS_X_AXIS) |-> (out_y_r == '0 && out_x_r != '0))
    else $error("x-axis class inconsistent with the point");

  // Vectoring the origin gives a zero radius and a zero angle.
  a_origin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_mode_r == MODE_TO_POLAR && out_x_r == '0 && out_y_r == '0)
      |-> (out_rad_r == '0 && out_ang_r == '0))
    else $error("origin gave a nonzero radius or angle");
`endif

endmodule
